>>> rtl/core/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and helpers for the integer to ascii digit converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int VALUE_PORT_W    = 64;
  localparam int REQ_TYPE_W      = 2;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;
  localparam logic [DIGIT_W-1:0] DEC_BASE  = 4'd10;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_SDEC = 2'd0,
    REQ_UDEC = 2'd1,
    REQ_HEXL = 2'd2,
    REQ_HEXU = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_SKIP = 2'd2,
    ST_EMIT = 2'd3
  } state_t;

  // one digit to its ascii code, hex letters in either case
  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DEC_BASE) begin
      return CHAR_ZERO + ext;
    end
    return (upper ? CHAR_A_UP : CHAR_A_LO) + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_BASE};
  endfunction

endpackage

>>> rtl/core/itoa_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa channel interfaces
// Request channel (mode and number) and character channel (code and last).
// ----------------------------------------------------------------------------
interface itoa_req_if import itoa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_TYPE_W-1:0]   req_type;
  logic [VALUE_PORT_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface itoa_char_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> rtl/core/itoa_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dabble
// Iterative binary to bcd converter: one shift and add-3 step per cycle.
// ----------------------------------------------------------------------------
module itoa_dabble import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int DEC_DIGITS  = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        mag,
  output logic                          done,
  output logic [DEC_DIGITS*DIGIT_W-1:0] bcd
);

  localparam int BCD_W = DEC_DIGITS * DIGIT_W;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] shift_r, shift_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [BCD_W-1:0]       adj;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = bcd_r[i*DIGIT_W +: DIGIT_W];
      adj[i*DIGIT_W +: DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = mag;
      bcd_nxt   = '0;
      cnt_nxt   = CNT_W'(VALUE_WIDTH);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = shift_r << 1;
      bcd_nxt   = {adj[BCD_W-2:0], shift_r[VALUE_WIDTH-1]};
      cnt_nxt   = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    bcd_r   <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

>>> rtl/core/integer_to_ascii_digits_core.sv
`timescale 1ns / 1ps
// sequence: decimal numbers go through the shift/add-3 loop, hex numbers do not;
// then leading zero digits are skipped one per cycle, the sign, if any, goes out
// as output starts, then one character per cycle while the output is not stalled
// requests: one number at a time, a new one is taken only when the last character of
// the previous number has been registered for output
// reset: synchronous active-low, clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_core
// Converts a number to ascii decimal or hex characters, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_core import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  itoa_req_if.sink     in_req,
  itoa_char_if.source  out_char
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_W      = NDIG * DIGIT_W;
  localparam int REM_W      = $clog2(NDIG + 1);

  state_t                       state_r, state_nxt;
  logic [DIG_W-1:0]             dig_r, dig_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic                         neg_r, neg_nxt;
  logic                         upper_r, upper_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]            out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         accept;
  logic                         slot_free;
  logic [VALUE_WIDTH-1:0]       v;
  logic                         v_neg;
  logic [VALUE_WIDTH-1:0]       mag;
  logic                         is_dec;
  logic                         dab_start;
  logic                         dab_done;
  logic [DEC_DIGITS*DIGIT_W-1:0] dab_bcd;
  logic [DIGIT_W-1:0]           top_digit;

  assign accept    = in_req.valid && in_req.ready;
  assign slot_free = !out_valid_r || out_char.ready;
  assign v         = in_req.value[VALUE_WIDTH-1:0];
  assign v_neg     = (in_req.req_type == REQ_SDEC) && v[VALUE_WIDTH-1];
  assign mag       = v_neg ? (VALUE_WIDTH'(0) - v) : v;
  assign is_dec    = (in_req.req_type == REQ_SDEC) || (in_req.req_type == REQ_UDEC);
  assign dab_start = accept && is_dec;
  assign top_digit = dig_r[DIG_W-1 -: DIGIT_W];

  itoa_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DEC_DIGITS  (DEC_DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_char.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = v_neg;
          upper_nxt = (in_req.req_type == REQ_HEXU);
          if (is_dec) begin
            rem_nxt   = REM_W'(DEC_DIGITS);
            state_nxt = ST_CONV;
          end else begin
            // left-align the nibbles so the top digit sits at the msb end
            dig_nxt   = DIG_W'(mag) << (DIG_W - HEX_DIGITS * DIGIT_W);
            rem_nxt   = REM_W'(HEX_DIGITS);
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          dig_nxt   = DIG_W'(dab_bcd) << (DIG_W - DEC_DIGITS * DIGIT_W);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && rem_r != REM_W'(1)) begin
          dig_nxt = dig_r << DIGIT_W;
          rem_nxt = rem_r - REM_W'(1);
        end else if (!neg_r) begin
          state_nxt = ST_EMIT;
        end else if (slot_free) begin
          // sign goes out first, digits follow
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          neg_nxt       = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(top_digit, upper_r);
          out_last_nxt  = (rem_r == REM_W'(1));
          dig_nxt       = dig_r << DIGIT_W;
          rem_nxt       = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_req.ready       = (state_r == ST_IDLE);
  assign out_char.valid     = out_valid_r;
  assign out_char.char_code = out_char_r;
  assign out_char.last      = out_last_r;

endmodule

>>> tb/tb_integer_to_ascii_digits_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits_core
// Sends numbers in all four modes to the converter and checks every character
// and last flag against a local model. Zeros, extremes and the most negative
// value go first, then random numbers of mixed lengths. In the last test
// the request side leaves random gaps, the character side stalls at random.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_digits_core;
  import itoa_pkg::*;

  localparam int    DRAIN_CYCLES = 100;
  localparam string HEX_LOWER    = "0123456789abcdef";
  localparam string HEX_UPPER    = "0123456789ABCDEF";

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  logic clk;
  logic rst_n;

  itoa_req_if  req_if ();
  itoa_char_if char_if ();

  integer_to_ascii_digits_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_char(char_if)
  );

  ascii_char_t pending_chars[$];
  int          mismatches = 0;
  int          chars_checked = 0;
  int          numbers_per_mode[4] = '{0, 0, 0, 0};
  int          req_gap = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short idles, now and then a long one
  function automatic int draw_idle(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  // expected characters of one number, most significant first
  function automatic void predict_digits(req_type_t mode, logic [VALUE_PORT_W-1:0] num);
    logic [VALUE_PORT_W-1:0] mag;
    logic [CHAR_W-1:0]       digits[$];
    logic [3:0]              nib;
    ascii_char_t             c;
    mag = num;
    if (mode == REQ_SDEC && num[VALUE_PORT_W-1]) begin
      mag = -num;
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    if (mode == REQ_SDEC || mode == REQ_UDEC) begin
      do begin
        digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
    end else begin
      do begin
        nib = mag[3:0];
        digits.push_front((mode == REQ_HEXU) ? HEX_UPPER[nib] : HEX_LOWER[nib]);
        mag = mag >> 4;
      end while (mag != 0);
    end
    foreach (digits[i]) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // valid is left high when the next request follows without a gap
  task automatic send_number(req_type_t mode, logic [VALUE_PORT_W-1:0] num);
    if (req_gap > 0) begin
      repeat (req_gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= mode;
    req_if.value    <= num;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_digits(mode, num);
    numbers_per_mode[mode]++;
    req_gap = draw_idle(gaps_on);
    if (req_gap > 0) begin
      req_if.valid <= 1'b0;
    end
  endtask

  // stop requesting and let every expected character come out
  task automatic wait_idle();
    if (req_gap == 0) begin
      req_if.valid <= 1'b0;
    end
    req_gap = 0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_PORT_W-1:0] random_number();
    logic [VALUE_PORT_W-1:0] v;
    logic [VALUE_PORT_W-1:0] mask;
    int r;
    v = {$urandom, $urandom};
    mask = (64'd1 << $urandom_range(1, 63)) - 1;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return v;
    end
    if (r < 7) begin
      return v & mask;
    end
    if (r < 9) begin
      // short negative numbers
      return -(v & mask);
    end
    return VALUE_PORT_W'($urandom_range(0, 20));
  endfunction

  task automatic test_zero();
    send_number(REQ_SDEC, '0);
    send_number(REQ_UDEC, '0);
    send_number(REQ_HEXL, '0);
    send_number(REQ_HEXU, '0);
    wait_idle();
  endtask

  task automatic test_signed_extremes();
    send_number(REQ_SDEC, 64'h8000_0000_0000_0000);
    send_number(REQ_SDEC, 64'h7fff_ffff_ffff_ffff);
    send_number(REQ_SDEC, '1);
    send_number(REQ_SDEC, 64'd1);
    send_number(REQ_SDEC, -64'd10);
    wait_idle();
  endtask

  task automatic test_unsigned_extremes();
    send_number(REQ_UDEC, '1);
    send_number(REQ_UDEC, 64'd10_000_000_000_000_000_000);
    send_number(REQ_UDEC, 64'h8000_0000_0000_0000);
    send_number(REQ_UDEC, 64'd9);
    send_number(REQ_UDEC, 64'd10);
    wait_idle();
  endtask

  task automatic test_hex_modes();
    send_number(REQ_HEXL, '1);
    send_number(REQ_HEXL, 64'habcd_ef01_2345_6789);
    send_number(REQ_HEXU, 64'hfedc_ba98_7654_3210);
    send_number(REQ_HEXU, 64'ha);
    wait_idle();
  endtask

  // no gaps and no stalls: requests back to back
  task automatic test_streaming(int count);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (count) send_number(req_type_t'($urandom_range(0, 3)), random_number());
    wait_idle();
  endtask

  task automatic test_random_traffic(int count);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_number(req_type_t'($urandom_range(0, 3)), random_number());
      // every so often hold off until the converter has emptied
      if (i % 30 == 29) begin
        wait_idle();
      end
    end
    wait_idle();
  endtask

  // character side back-pressure
  initial begin
    int hold;
    hold = 0;
    char_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        char_if.ready <= 1'b0;
        hold--;
      end else begin
        hold = draw_idle(stalls_on);
        char_if.ready <= (hold == 0);
        if (hold > 0) begin
          hold--;
        end
      end
    end
  end

  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n && char_if.valid && char_if.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, got code %h last %b",
                 $time, char_if.char_code, char_if.last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (char_if.char_code !== want.code || char_if.last !== want.last) begin
          $display("%0t: char mismatch: expected code %h last %b, got code %h last %b",
                   $time, want.code, want.last, char_if.char_code, char_if.last);
          mismatches++;
        end
        chars_checked++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_SDEC;
    req_if.value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero();
    test_signed_extremes();
    test_unsigned_extremes();
    test_hex_modes();
    test_streaming(20);
    test_random_traffic(90);

    $display("covered %0d numbers: signed %0d, unsigned %0d, hex lower %0d, hex upper %0d",
             numbers_per_mode[REQ_SDEC] + numbers_per_mode[REQ_UDEC]
               + numbers_per_mode[REQ_HEXL] + numbers_per_mode[REQ_HEXU],
             numbers_per_mode[REQ_SDEC], numbers_per_mode[REQ_UDEC],
             numbers_per_mode[REQ_HEXL], numbers_per_mode[REQ_HEXU]);
    $display("%0d characters checked, %0d mismatches", chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_integer_to_ascii_digits_core passed");
    end else begin
      $display("tb_integer_to_ascii_digits_core failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d characters still expected", pending_chars.size());
    $display("tb_integer_to_ascii_digits_core failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/itoa_pkg.sv
rtl/core/itoa_ifs.sv
rtl/core/itoa_dabble.sv
rtl/core/integer_to_ascii_digits_core.sv
tb/tb_integer_to_ascii_digits_core.sv
